### rtl/iss_pkg.sv
package iss_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VAL_W     = 32;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic ins;
		logic shf;
	} cell_ctl_t;

endpackage

### rtl/iss_cell.sv
module iss_cell (
	input  logic             clk,
	input  iss_pkg::cell_ctl_t ctl,
	input  logic             occ,
	input  iss_pkg::val_t    din,
	input  logic             left_le,
	input  iss_pkg::val_t    left_val,
	input  iss_pkg::val_t    right_val,
	output iss_pkg::val_t    val,
	output logic             le
);
	import iss_pkg::*;

	val_t val_q;

	assign val = val_q;
	assign le  = occ && (val_q <= din);

	always_ff @(posedge clk) begin
		if (ctl.shf) begin
			val_q <= right_val;
		end else if (ctl.ins && !le) begin
			val_q <= left_le ? din : left_val;
		end
	end

endmodule

### rtl/insertion_sorter_top.sv
// Stable insertion sorter for sets of signed 32-bit values.
// Input channel: s_tdata carries one value per item, s_tlast marks the final
// value of a set. While a set loads, one item is taken every cycle; each value
// is inserted by a row of MAX_ITEMS cells that all compare against it in
// parallel and shift the larger entries up by one.
// After the last item the block stops taking input and drains the row: one
// result per cycle on m_tdata while the receiver is ready, lowest value first,
// m_tlast on the final one, m_tuser high on every result of a set that lost
// values to a full row. The first result is shown the cycle after the last
// item is taken. Values beyond MAX_ITEMS are dropped. A stalled receiver
// holds the current result and freezes the drain; input stays blocked until
// the set is out. Reset empties the row and clears the overflow mark; cell
// contents are not cleared, since only occupied cells are ever read.
module insertion_sorter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] value_res
	output logic        m_tlast,
	output logic        m_tuser   // [0] overflow
);
	import iss_pkg::*;

	state_t    state_q, state_d;
	cnt_t      cnt_q;
	logic      ovf_q;
	logic      in_acc, out_acc, full;
	cell_ctl_t ctl;
	val_t      din;
	val_t      cval [MAX_ITEMS];
	logic      cle  [MAX_ITEMS];
	logic      occ  [MAX_ITEMS];

	assign din     = val_t'(s_tdata);
	assign full    = (cnt_q == CNT_W'(MAX_ITEMS));
	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign ctl.ins = in_acc && !full;
	assign ctl.shf = out_acc;

	genvar i;
	generate
		for (i = 0; i < MAX_ITEMS; i++) begin : g_cell
			assign occ[i] = (cnt_q > CNT_W'(i));
			iss_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.occ       (occ[i]),
				.din       (din),
				.left_le   ((i == 0) ? 1'b1 : cle[(i == 0) ? 0 : i - 1]),
				.left_val  (cval[(i == 0) ? 0 : i - 1]),
				.right_val (cval[(i == MAX_ITEMS - 1) ? i : i + 1]),
				.val       (cval[i]),
				.le        (cle[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (in_acc && s_tlast) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				m_tvalid = 1'b1;
				if (out_acc && cnt_q == CNT_W'(1)) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (out_acc) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (in_acc && full) begin
				ovf_q <= 1'b1;
			end else if (out_acc && m_tlast) begin
				ovf_q <= 1'b0;
			end
		end
	end

	assign m_tdata = cval[0];
	assign m_tlast = (cnt_q == CNT_W'(1));
	assign m_tuser = ovf_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("held count beyond capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != '0)
		else $error("result shown from an empty row");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		occ[1] |-> cval[1] >= cval[0])
		else $error("row out of order");

	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tlast |=> m_tvalid && !s_tready)
		else $error("last item did not start the drain");

endmodule
